// ----- design/frm_pkg.sv -----
`default_nettype none

package frm_pkg;

  // history depth and limits
  localparam int Window     = 100;
  localparam int HistCap    = Window - 1;
  localparam int MinSamples = 10;
  localparam int RateScale  = 10000;

  // field widths
  localparam int CntW  = 7;
  localparam int RunW  = 16;
  localparam int RateW = 14;
  localparam int ProdW = CntW + RateW;

  localparam logic [RunW-1:0] RunMax = {RunW{1'b1}};

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE     = 2'd0,
    REG_RUN_LIMIT  = 2'd1,
    REG_RATE_LIMIT = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_CHECK  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             enable;
    logic [RunW-1:0]  run_limit;
    logic [RateW-1:0] rate_limit;
  } cfg_t;

  typedef struct packed {
    logic            alarm;
    logic [RunW-1:0] run_count;
    logic [CntW-1:0] window_fails;
    logic [CntW-1:0] window_held;
  } res_t;

endpackage

`default_nettype wire

// ----- design/frm_if.sv -----
`default_nettype none

interface frm_in_if;
  logic valid;
  logic ready;
  logic command;
  logic fail;

  modport source (output valid, output command, output fail, input ready);
  modport sink   (input valid, input command, input fail, output ready);
endinterface

interface frm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       alarm;
  logic [frm_pkg::RunW-1:0]   run_count;
  logic [frm_pkg::CntW-1:0]   window_fails;
  logic [frm_pkg::CntW-1:0]   window_held;

  modport source (output valid, output alarm, output run_count, output window_fails,
                  output window_held, input ready);
  modport sink   (input valid, input alarm, input run_count, input window_fails,
                  input window_held, output ready);
endinterface

interface frm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [frm_pkg::CfgIdxW-1:0]    index;
  logic [frm_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/fail_run_and_window_rate_alarm.sv -----
`default_nettype none

// channel   dir   payload                                          handshake
// in_i      in    command, fail                                    valid/ready
// out_o     out   alarm, run_count, window_fails, window_held      valid/ready
// cfg_i     in    index (0 enable, 1 run_limit, 2 rate), data      valid/ready, ready tied high
//
// one item per cycle sustained while out_o is not stalled; a result is valid once its item has passed
// the input register and then the update and result register, which both load when the item advances
// the whole state update is one pass of counters, a shift and a compare
// rst_ni resets all monitor state and config (rate limit to RateScale) at once, no clearing pass
// a stalled output holds the result; the input register still takes one more item

module fail_run_and_window_rate_alarm (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  frm_in_if.sink    in_i,
  frm_out_if.source out_o,
  frm_cfg_if.sink   cfg_i
);

  frm_pkg::cfg_t cfg;
  frm_pkg::res_t res, res_q;

  logic s1_valid_q, s1_cmd_q, s1_fail_q;
  logic out_valid_q;
  logic adv;

  // the item in the input register moves on when the result register is free
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  frm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  frm_monitor u_monitor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (adv),
    .command_i (s1_cmd_q),
    .fail_i    (s1_fail_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_cmd_q  <= in_i.command;
      s1_fail_q <= in_i.fail;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.alarm        = res_q.alarm;
  assign out_o.run_count    = res_q.run_count;
  assign out_o.window_fails = res_q.window_fails;
  assign out_o.window_held  = res_q.window_held;

endmodule

`default_nettype wire

// ----- design/frm_cfg.sv -----
`default_nettype none

module frm_cfg (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  frm_cfg_if.sink      cfg_i,
  output frm_pkg::cfg_t cfg_o
);

  frm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        frm_pkg::REG_ENABLE:     cfg_d.enable     = cfg_i.data[0];
        frm_pkg::REG_RUN_LIMIT:  cfg_d.run_limit  = cfg_i.data[frm_pkg::RunW-1:0];
        frm_pkg::REG_RATE_LIMIT: cfg_d.rate_limit = cfg_i.data[frm_pkg::RateW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b0;
      cfg_q.run_limit  <= '0;
      cfg_q.rate_limit <= frm_pkg::RateW'(frm_pkg::RateScale);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/frm_monitor.sv -----
`default_nettype none

module frm_monitor (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire frm_pkg::cfg_t cfg_i,
  input  wire logic     fire_i,
  input  wire logic     command_i,
  input  wire logic     fail_i,
  output frm_pkg::res_t res_o
);

  localparam int HistCap = frm_pkg::HistCap;
  localparam int CntW    = frm_pkg::CntW;
  localparam int RunW    = frm_pkg::RunW;
  localparam int ProdW   = frm_pkg::ProdW;

  // history as a shift line: newest at bit 0, oldest held entry at the top when full
  logic [HistCap-1:0] hist_q, hist_d;
  logic [CntW-1:0]    held_q, held_d;
  logic [CntW-1:0]    fails_q, fails_d;
  logic               in_run_q, in_run_d;
  logic [RunW-1:0]    run_q, run_d;

  logic             rec, chk, full, drop, run_hit, rate_hit, alarm;
  logic [ProdW-1:0] fail_scaled, held_scaled;

  assign rec  = cfg_i.enable && (command_i == frm_pkg::CMD_RECORD);
  assign chk  = cfg_i.enable && (command_i == frm_pkg::CMD_CHECK);
  assign full = (held_q == CntW'(HistCap));
  assign drop = full && hist_q[HistCap-1];

  assign fail_scaled = ProdW'(fails_q) * ProdW'(frm_pkg::RateScale);
  assign held_scaled = ProdW'(cfg_i.rate_limit) * ProdW'(held_q);

  assign run_hit  = in_run_q && (run_q >= cfg_i.run_limit);
  assign rate_hit = (held_q >= CntW'(frm_pkg::MinSamples)) && (fail_scaled >= held_scaled);
  assign alarm    = chk && (run_hit || rate_hit);

  always_comb begin
    hist_d   = hist_q;
    held_d   = held_q;
    fails_d  = fails_q;
    in_run_d = in_run_q;
    run_d    = run_q;
    if (rec) begin
      hist_d   = {hist_q[HistCap-2:0], fail_i};
      held_d   = full ? held_q : held_q + 1'b1;
      fails_d  = fails_q + CntW'(fail_i) - CntW'(drop);
      in_run_d = fail_i;
      if (!fail_i) begin
        run_d = '0;
      end else if (!in_run_q) begin
        run_d = RunW'(1);
      end else if (run_q != frm_pkg::RunMax) begin
        run_d = run_q + 1'b1;
      end
    end else if (alarm) begin
      hist_d   = '0;
      held_d   = '0;
      fails_d  = '0;
      in_run_d = 1'b0;
      run_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= '0;
      held_q   <= '0;
      fails_q  <= '0;
      in_run_q <= 1'b0;
      run_q    <= '0;
    end else if (fire_i) begin
      hist_q   <= hist_d;
      held_q   <= held_d;
      fails_q  <= fails_d;
      in_run_q <= in_run_d;
      run_q    <= run_d;
    end
  end

  assign res_o.alarm        = alarm;
  assign res_o.run_count    = run_d;
  assign res_o.window_fails = fails_d;
  assign res_o.window_held  = held_d;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(HistCap))
    else $error("history count above capacity");

  a_fails_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fails_q <= held_q)
    else $error("fail count above held count");

  a_run_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_run_q == (run_q != '0))
    else $error("run flag and run length disagree");

  a_alarm_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && alarm |=> held_q == '0 && fails_q == '0 && run_q == '0 && hist_q == '0)
    else $error("state not cleared after alarm");

  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !cfg_i.enable |=> $stable(held_q) && $stable(fails_q) && $stable(run_q))
    else $error("state changed while disabled");

endmodule

`default_nettype wire
